// File: hw/rtl/msbr_pkg.sv
// Shared types, codes and constants for the motor speed and brake ramp.
package msbr_pkg;

    // Widths of the item fields
    localparam int SPEED_W = 16;
    localparam int LEVEL_W = 15;
    localparam int STEP_W  = 15;
    localparam int GAIN_W  = 16;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stream word layouts
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 40;

    // Target speed saturates symmetrically at this magnitude
    localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 16'sd32767;

    // Register reset values
    localparam logic [STEP_W-1:0]         RST_SPEED_STEP = 15'd64;
    localparam logic [STEP_W-1:0]         RST_BRAKE_STEP = 15'd64;
    localparam logic [LEVEL_W-1:0]        RST_MAX_POS    = 15'd127;
    localparam logic [LEVEL_W-1:0]        RST_MIN_POS    = 15'd0;
    localparam logic signed [SPEED_W-1:0] RST_MAX_NEG    = -16'sd127;
    localparam logic signed [SPEED_W-1:0] RST_MIN_NEG    = 16'sd0;
    localparam logic [GAIN_W-1:0]         RST_GAIN       = 16'd258;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_BRAKE = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_STEP = 3'd0,
        CFG_BRAKE_STEP = 3'd1,
        CFG_INVERT     = 3'd2,
        CFG_MAX_POS    = 3'd3,
        CFG_MIN_POS    = 3'd4,
        CFG_MAX_NEG    = 3'd5,
        CFG_MIN_NEG    = 3'd6,
        CFG_GAIN       = 3'd7
    } t_cfg_idx;

    // Settings that shape a set-speed command
    typedef struct packed {
        logic                        invert;
        logic [LEVEL_W-1:0]          max_pos;
        logic [LEVEL_W-1:0]          min_pos;
        logic signed [SPEED_W-1:0]   max_neg;
        logic signed [SPEED_W-1:0]   min_neg;
        logic [GAIN_W-1:0]           gain;
    } t_shape_cfg;

    // Result of one ramp step
    typedef struct packed {
        logic signed [SPEED_W-1:0] value;
        logic                      moved;
    } t_ramp_res;

endpackage

// File: hw/rtl/motor_speed_brake_ramp_top.sv
// Top level of the motor speed and brake ramp: registers, handshakes and state.
//
// Usage:
//   Slave stream carries commands: tuser holds the command code (tick, set
//   speed, stop, brake), tdata the speed command and the brake level.
//   Master stream returns exactly one word per command: the current speed,
//   the current brake and the two update flags after that command.
//   Configuration channel writes one register per handshake (index, data);
//   it is always ready and should be used only while the block is idle.
// Timing:
//   A command is taken into an input register, worked through the shaping,
//   ramp and gain-multiply logic, and its word is then loaded into the
//   output register, which drives tvalid. One command per cycle is sustained
//   while the receiver takes each word; the gain multiply on the set-speed
//   path sets the clock limit.
// Reset (synchronous, active low) clears speeds, brakes, targets and both
// valid flags and loads the register defaults. When the receiver stalls, the
// output word holds and one further command waits in the input register;
// tready then drops until the output word is taken.
module motor_speed_brake_ramp_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Command words
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] speed_command, [30:16] brake_level, [31] zero
    input  logic [msbr_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [1:0] command
    input  logic [msbr_pkg::S_TUSER_W-1:0]     i_s_axis_tuser,
    // Result words
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [15:0] speed_now, [30:16] brake_now, [31] speed_updated,
    // [32] brake_updated, [39:33] zero
    output logic [msbr_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // Configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [msbr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [msbr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic [msbr_pkg::STEP_W-1:0]  r_speed_step;
    logic [msbr_pkg::STEP_W-1:0]  r_brake_step;
    msbr_pkg::t_shape_cfg         r_shape_cfg;

    // Input register
    logic                               r_in_valid;
    msbr_pkg::t_cmd                     r_in_cmd;
    logic signed [msbr_pkg::SPEED_W-1:0] r_in_speed_cmd;
    logic [msbr_pkg::LEVEL_W-1:0]       r_in_brake_lvl;

    // Ramp state
    logic signed [msbr_pkg::SPEED_W-1:0] r_cur_speed;
    logic signed [msbr_pkg::SPEED_W-1:0] r_tgt_speed;
    logic [msbr_pkg::LEVEL_W-1:0]       r_cur_brake;
    logic [msbr_pkg::LEVEL_W-1:0]       r_tgt_brake;
    logic signed [msbr_pkg::SPEED_W-1:0] n_cur_speed;
    logic signed [msbr_pkg::SPEED_W-1:0] n_tgt_speed;
    logic [msbr_pkg::LEVEL_W-1:0]       n_cur_brake;
    logic [msbr_pkg::LEVEL_W-1:0]       n_tgt_brake;
    logic                               n_spd_upd;
    logic                               n_brk_upd;

    // Output register
    logic                               r_out_valid;
    logic [msbr_pkg::M_TDATA_W-1:0]     r_out_data;

    logic                               w_s_accept;
    logic                               w_advance;
    logic signed [msbr_pkg::SPEED_W-1:0] w_shaped;
    msbr_pkg::t_ramp_res                w_spd_ramp;
    msbr_pkg::t_ramp_res                w_brk_ramp;

    // Handshakes
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_step        <= msbr_pkg::RST_SPEED_STEP;
            r_brake_step        <= msbr_pkg::RST_BRAKE_STEP;
            r_shape_cfg.invert  <= 1'b0;
            r_shape_cfg.max_pos <= msbr_pkg::RST_MAX_POS;
            r_shape_cfg.min_pos <= msbr_pkg::RST_MIN_POS;
            r_shape_cfg.max_neg <= msbr_pkg::RST_MAX_NEG;
            r_shape_cfg.min_neg <= msbr_pkg::RST_MIN_NEG;
            r_shape_cfg.gain    <= msbr_pkg::RST_GAIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (msbr_pkg::t_cfg_idx'(i_cfg_index))
                msbr_pkg::CFG_SPEED_STEP: r_speed_step <= i_cfg_data[msbr_pkg::STEP_W-1:0];
                msbr_pkg::CFG_BRAKE_STEP: r_brake_step <= i_cfg_data[msbr_pkg::STEP_W-1:0];
                msbr_pkg::CFG_INVERT:     r_shape_cfg.invert <= i_cfg_data[0];
                msbr_pkg::CFG_MAX_POS: begin
                    r_shape_cfg.max_pos <= i_cfg_data[msbr_pkg::LEVEL_W-1:0];
                end
                msbr_pkg::CFG_MIN_POS: begin
                    r_shape_cfg.min_pos <= i_cfg_data[msbr_pkg::LEVEL_W-1:0];
                end
                msbr_pkg::CFG_MAX_NEG: r_shape_cfg.max_neg <= $signed(i_cfg_data);
                msbr_pkg::CFG_MIN_NEG: r_shape_cfg.min_neg <= $signed(i_cfg_data);
                msbr_pkg::CFG_GAIN:    r_shape_cfg.gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture a command word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_cmd       <= msbr_pkg::t_cmd'(i_s_axis_tuser[msbr_pkg::CMD_W-1:0]);
            r_in_speed_cmd <= $signed(i_s_axis_tdata[msbr_pkg::SPEED_W-1:0]);
            r_in_brake_lvl <= i_s_axis_tdata[msbr_pkg::SPEED_W +: msbr_pkg::LEVEL_W];
        end
    end

    msbr_shaper u_shaper (
        .i_speed_command (r_in_speed_cmd),
        .i_cfg           (r_shape_cfg),
        .o_target        (w_shaped)
    );

    msbr_ramp u_speed_ramp (
        .i_value  (r_cur_speed),
        .i_target (r_tgt_speed),
        .i_step   (r_speed_step),
        .o_res    (w_spd_ramp)
    );

    msbr_ramp u_brake_ramp (
        .i_value  ($signed({1'b0, r_cur_brake})),
        .i_target ($signed({1'b0, r_tgt_brake})),
        .i_step   (r_brake_step),
        .o_res    (w_brk_ramp)
    );

    // Next state for the command in the input register
    always_comb begin
        n_cur_speed = r_cur_speed;
        n_tgt_speed = r_tgt_speed;
        n_cur_brake = r_cur_brake;
        n_tgt_brake = r_tgt_brake;
        n_spd_upd   = 1'b0;
        n_brk_upd   = 1'b0;
        case (r_in_cmd)
            msbr_pkg::CMD_TICK: begin
                // Brake ramps only once speed has settled
                if (r_cur_speed != r_tgt_speed) begin
                    n_cur_speed = w_spd_ramp.value;
                    n_spd_upd   = w_spd_ramp.moved;
                end else begin
                    n_cur_brake = w_brk_ramp.value[msbr_pkg::LEVEL_W-1:0];
                    n_brk_upd   = w_brk_ramp.moved;
                end
            end
            msbr_pkg::CMD_SET: n_tgt_speed = w_shaped;
            msbr_pkg::CMD_STOP: n_tgt_speed = '0;
            msbr_pkg::CMD_BRAKE: begin
                n_tgt_brake = r_in_brake_lvl;
                n_tgt_speed = '0;
            end
            default: ;
        endcase
    end

    // Advance state and load the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_speed <= '0;
            r_tgt_speed <= '0;
            r_cur_brake <= '0;
            r_tgt_brake <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_cur_speed <= n_cur_speed;
                r_tgt_speed <= n_tgt_speed;
                r_cur_brake <= n_cur_brake;
                r_tgt_brake <= n_tgt_brake;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {7'b0, n_brk_upd, n_spd_upd, n_cur_brake, n_cur_speed};
        end
    end

    // A result word never reports both ramps moving
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[31] && r_out_data[32]))
        else $error("speed and brake both updated in one word");

    // Commands other than tick leave the ramped values alone
    a_no_ramp_off_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_cmd != msbr_pkg::CMD_TICK)
        |=> ($stable(r_cur_speed) && $stable(r_cur_brake)))
        else $error("ramped value moved on a non-tick command");

    // Brake moves only when speed had settled
    a_brake_after_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cur_brake) |-> $past(r_cur_speed == r_tgt_speed))
        else $error("brake ramped while speed unsettled");

    // Speed stays inside the symmetric range
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_speed != -16'sd32768) && (r_tgt_speed != -16'sd32768))
        else $error("speed left the symmetric range");

endmodule

// File: hw/rtl/msbr_ramp.sv
// One slew-limited step of a value toward its target.
module msbr_ramp (
    input  logic signed [msbr_pkg::SPEED_W-1:0] i_value,
    input  logic signed [msbr_pkg::SPEED_W-1:0] i_target,
    input  logic        [msbr_pkg::STEP_W-1:0]  i_step,
    output msbr_pkg::t_ramp_res                 o_res
);

    logic signed [msbr_pkg::SPEED_W:0] w_diff;
    logic        [msbr_pkg::SPEED_W:0] w_mag;
    logic        [msbr_pkg::STEP_W-1:0] w_step;
    logic signed [msbr_pkg::SPEED_W:0] w_step_x;
    logic signed [msbr_pkg::SPEED_W:0] w_up;
    logic signed [msbr_pkg::SPEED_W:0] w_down;

    // Distance to target and its magnitude
    assign w_diff = {i_target[msbr_pkg::SPEED_W-1], i_target}
                  - {i_value[msbr_pkg::SPEED_W-1], i_value};
    assign w_mag  = w_diff[msbr_pkg::SPEED_W] ? (~w_diff + 1'b1) : w_diff;

    // A zero step still moves by one
    assign w_step   = (i_step == '0) ? msbr_pkg::STEP_W'(1) : i_step;
    assign w_step_x = $signed({2'b00, w_step});
    assign w_up     = {i_value[msbr_pkg::SPEED_W-1], i_value} + w_step_x;
    assign w_down   = {i_value[msbr_pkg::SPEED_W-1], i_value} - w_step_x;

    // Hold, snap or step
    always_comb begin
        o_res.moved = 1'b1;
        o_res.value = i_value;
        if (w_diff == '0) begin
            o_res.moved = 1'b0;
        end else if (w_mag < {2'b00, w_step}) begin
            o_res.value = i_target;
        end else if (!w_diff[msbr_pkg::SPEED_W]) begin
            o_res.value = w_up[msbr_pkg::SPEED_W-1:0];
        end else begin
            o_res.value = w_down[msbr_pkg::SPEED_W-1:0];
        end
    end

endmodule

// File: hw/rtl/msbr_shaper.sv
// Set-speed command shaping: invert, clamp, dead band, gain and saturation.
module msbr_shaper (
    input  logic signed [msbr_pkg::SPEED_W-1:0] i_speed_command,
    input  msbr_pkg::t_shape_cfg                i_cfg,
    output logic signed [msbr_pkg::SPEED_W-1:0] o_target
);

    localparam int VW = msbr_pkg::SPEED_W + 2;
    localparam int PW = VW + msbr_pkg::GAIN_W + 1;

    logic signed [VW-1:0] w_raw;
    logic signed [VW-1:0] w_inv;
    logic signed [VW-1:0] w_pos;
    logic signed [VW-1:0] w_lim;
    logic signed [VW-1:0] w_maxp;
    logic signed [VW-1:0] w_minp;
    logic signed [VW-1:0] w_maxn;
    logic signed [VW-1:0] w_minn;
    logic signed [msbr_pkg::GAIN_W:0] w_gain;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_hi;
    logic signed [PW-1:0] w_lo;

    assign w_raw  = VW'(i_speed_command);
    assign w_maxp = $signed({3'b000, i_cfg.max_pos});
    assign w_minp = $signed({3'b000, i_cfg.min_pos});
    assign w_maxn = VW'(i_cfg.max_neg);
    assign w_minn = VW'(i_cfg.min_neg);
    assign w_gain = $signed({1'b0, i_cfg.gain});

    // Negate without wrap
    assign w_inv = i_cfg.invert ? -w_raw : w_raw;

    // Clamp and dead band on the positive side, then the negative side
    always_comb begin
        w_pos = w_inv;
        if (w_inv > w_maxp) begin
            w_pos = w_maxp;
        end else if (w_inv > 0 && w_inv < w_minp) begin
            w_pos = '0;
        end
        w_lim = w_pos;
        if (w_pos < w_maxn) begin
            w_lim = w_maxn;
        end else if (w_pos < 0 && w_pos > w_minn) begin
            w_lim = '0;
        end
    end

    // Scale and saturate
    assign w_prod = PW'(w_lim) * PW'(w_gain);
    assign w_hi   = PW'(msbr_pkg::SPEED_LIMIT);
    assign w_lo   = -PW'(msbr_pkg::SPEED_LIMIT);

    always_comb begin
        if (w_prod > w_hi) begin
            o_target = msbr_pkg::SPEED_LIMIT;
        end else if (w_prod < w_lo) begin
            o_target = -msbr_pkg::SPEED_LIMIT;
        end else begin
            o_target = w_prod[msbr_pkg::SPEED_W-1:0];
        end
    end

endmodule
